// ----- rtl/core/periodic_task_timer_table_assert.svh -----
// Assertion macros shared by the timer table RTL.
`ifndef PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define PTT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ptt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

    localparam int CODE_W      = 8;
    localparam int TIME_W      = 24;
    localparam int SLOT_W      = 6;
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_W      = 4;

    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_DEL  = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;
    localparam logic [1:0] KIND_DISP = 2'd3;

    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_NONE = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CODE_W-1:0] task_code;
        logic [TIME_W-1:0] delay_ms;
        logic [TIME_W-1:0] period_ms;
        logic [SLOT_W-1:0] slot_index;
    } ptt_cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [CODE_W-1:0] fired_code;
        logic              last;
    } ptt_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_ADD_DIV,
        ST_ADD_WRITE,
        ST_TICK,
        ST_DISP_SCAN,
        ST_DISP_EMIT,
        ST_REPLY
    } ptt_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/periodic_task_timer_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Add: free-slot scan, reciprocal multiply, write, reply.
// Tick: one slot per cycle through the table memory.
// Dispatch: one word per fired slot, at most 16 words, or a single NONE word if none is ready.
// One command is in flight at a time; the response register frees the output side.
// Reset clears the occupied and ready flags; the table memory is not cleared, since
// only occupied entries are ever read.

`include "periodic_task_timer_table_assert.svh"

module periodic_task_timer_table
    import ptt_pkg::*;
#(
    parameter int SLOTS       = 16,
    parameter int TICK_LEN_MS = 10
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_ready,
    input  wire ptt_cmd_t cmd,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output ptt_rsp_t      rsp
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int DIV_SH = TIME_W + $clog2(TICK_LEN_MS);
    localparam int RCP_W  = TIME_W + 2;
    localparam int PROD_W = TIME_W + RCP_W;
    localparam longint RCP_VAL = ((longint'(1) << DIV_SH) + longint'(TICK_LEN_MS) - 1)
                                 / longint'(TICK_LEN_MS);
    localparam logic [CNT_W-1:0]   CNT_END  = CNT_W'(SLOTS);
    localparam logic [RCP_W-1:0]   RCP      = RCP_W'(RCP_VAL);
    localparam logic [SLOT_W:0]    SLOT_LIM = (SLOT_W + 1)'(SLOTS);
    localparam logic [FIRE_W-1:0]  FIRE_MAX = FIRE_W'(MAX_RESULTS - 1);

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [TIME_W-1:0] dly;
        logic [TIME_W-1:0] per;
    } entry_t;

    entry_t mem [SLOTS];
    entry_t mem_rdata_reg;
    logic   mem_we;
    logic   [IDX_W-1:0] mem_waddr;
    logic   [IDX_W-1:0] mem_raddr;
    entry_t mem_wdata;

    ptt_state_t state_reg, state_next;
    ptt_cmd_t   cmd_q_reg, cmd_q_next;
    ptt_rsp_t   rsp_reg, rsp_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               tk_vld_reg, tk_vld_next;
    logic [IDX_W-1:0]   tk_idx_reg, tk_idx_next;
    logic [SLOTS-1:0]   used_reg, used_next;
    logic [SLOTS-1:0]   ready_reg, ready_next;
    logic [FIRE_W-1:0]  nfired_reg, nfired_next;
    logic [TIME_W-1:0]  dq_reg, dq_next;
    logic [TIME_W-1:0]  pq_reg, pq_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;

    logic [IDX_W-1:0]  cur;
    logic              cnt_end;
    logic              rsp_free;
    logic              later_ready;
    logic              disp_last;
    logic [PROD_W-1:0] dprod;
    logic [PROD_W-1:0] pprod;

    assign cur       = cnt_reg[IDX_W-1:0];
    assign cnt_end   = (cnt_reg == CNT_END);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign mem_raddr = cnt_end ? '0 : cur;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign dprod     = {{RCP_W{1'b0}}, cmd_q_reg.delay_ms} * {{TIME_W{1'b0}}, RCP};
    assign pprod     = {{RCP_W{1'b0}}, cmd_q_reg.period_ms} * {{TIME_W{1'b0}}, RCP};
    assign disp_last = later_ready ? (nfired_reg == FIRE_MAX) : 1'b1;

    always_comb
    begin
        later_ready = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (ready_reg[j] && (CNT_W'(j) > cnt_reg))
            begin
                later_ready = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        KIND_ADD:  state_next = ST_ADD_SCAN;
                        KIND_TICK: state_next = ST_TICK;
                        KIND_DISP: state_next = ST_DISP_SCAN;
                        default:   state_next = ST_REPLY;
                    endcase
                end
            end
            ST_ADD_SCAN:
            begin
                if (cnt_end)
                begin
                    state_next = ST_REPLY;
                end
                else if (!used_reg[cur])
                begin
                    state_next = ST_ADD_DIV;
                end
            end
            ST_ADD_DIV:
            begin
                state_next = ST_ADD_WRITE;
            end
            ST_ADD_WRITE:
            begin
                state_next = ST_REPLY;
            end
            ST_TICK:
            begin
                if (cnt_end && !tk_vld_reg)
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_DISP_SCAN:
            begin
                if (cnt_end)
                begin
                    state_next = ST_REPLY;
                end
                else if (ready_reg[cur])
                begin
                    state_next = ST_DISP_EMIT;
                end
            end
            ST_DISP_EMIT:
            begin
                if (rsp_free)
                begin
                    state_next = disp_last ? ST_IDLE : ST_DISP_SCAN;
                end
            end
            ST_REPLY:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_q_next      = cmd_q_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        cnt_next        = cnt_reg;
        tk_vld_next     = 1'b0;
        tk_idx_next     = tk_idx_reg;
        used_next       = used_reg;
        ready_next      = ready_reg;
        nfired_next     = nfired_reg;
        dq_next         = dq_reg;
        pq_next         = pq_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        mem_we          = 1'b0;
        mem_waddr       = cur;
        mem_wdata       = mem_rdata_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_q_next      = cmd;
                    cnt_next        = '0;
                    nfired_next     = '0;
                    res_status_next = STAT_DONE;
                    res_slot_next   = '0;
                    if (cmd.kind == KIND_DEL && {1'b0, cmd.slot_index} < SLOT_LIM)
                    begin
                        used_next[cmd.slot_index[IDX_W-1:0]]  = 1'b0;
                        ready_next[cmd.slot_index[IDX_W-1:0]] = 1'b0;
                    end
                end
            end
            ST_ADD_SCAN:
            begin
                if (cnt_end)
                begin
                    res_status_next = STAT_FULL;
                end
                else if (used_reg[cur])
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ADD_DIV:
            begin
                dq_next = TIME_W'(dprod >> DIV_SH);
                pq_next = TIME_W'(pprod >> DIV_SH);
            end
            ST_ADD_WRITE:
            begin
                mem_we          = 1'b1;
                mem_waddr       = cur;
                mem_wdata.code  = cmd_q_reg.task_code;
                mem_wdata.dly   = dq_reg;
                mem_wdata.per   = pq_reg;
                used_next[cur]  = 1'b1;
                ready_next[cur] = 1'b0;
                res_slot_next   = SLOT_W'(cur);
            end
            ST_TICK:
            begin
                if (!cnt_end)
                begin
                    cnt_next    = cnt_reg + 1'b1;
                    tk_vld_next = 1'b1;
                    tk_idx_next = cur;
                end
                mem_waddr = tk_idx_reg;
                if (tk_vld_reg && used_reg[tk_idx_reg])
                begin
                    if (mem_rdata_reg.dly != '0)
                    begin
                        mem_we        = 1'b1;
                        mem_wdata.dly = mem_rdata_reg.dly - 1'b1;
                    end
                    else
                    begin
                        ready_next[tk_idx_reg] = 1'b1;
                        if (mem_rdata_reg.per != '0)
                        begin
                            mem_we        = 1'b1;
                            mem_wdata.dly = mem_rdata_reg.per;
                        end
                    end
                end
            end
            ST_DISP_SCAN:
            begin
                if (cnt_end)
                begin
                    res_status_next = STAT_NONE;
                end
                else if (!ready_reg[cur])
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DISP_EMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.status     = STAT_DONE;
                    rsp_next.slot       = SLOT_W'(cur);
                    rsp_next.fired_code = mem_rdata_reg.code;
                    rsp_next.last       = disp_last;
                    ready_next[cur]     = 1'b0;
                    if (mem_rdata_reg.per == '0)
                    begin
                        used_next[cur] = 1'b0;
                    end
                    nfired_next = nfired_reg + 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
            end
            ST_REPLY:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.status     = res_status_reg;
                    rsp_next.slot       = res_slot_reg;
                    rsp_next.fired_code = '0;
                    rsp_next.last       = 1'b1;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            used_reg      <= '0;
            ready_reg     <= '0;
            tk_vld_reg    <= 1'b0;
            cnt_reg       <= '0;
            nfired_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            used_reg      <= used_next;
            ready_reg     <= ready_next;
            tk_vld_reg    <= tk_vld_next;
            cnt_reg       <= cnt_next;
            nfired_reg    <= nfired_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_q_reg      <= cmd_q_next;
        rsp_reg        <= rsp_next;
        tk_idx_reg     <= tk_idx_next;
        dq_reg         <= dq_next;
        pq_reg         <= pq_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
    end

    `PTT_ASSERT_NOW(a_ready_implies_used, 1'b1, (ready_reg & ~used_reg) == '0,
        "ready flag set on a free slot")
    `PTT_ASSERT_NOW(a_tick_no_overlap, mem_we && state_reg == ST_TICK && !cnt_end,
        mem_waddr != mem_raddr, "tick write-back hits the entry being read")
    `PTT_ASSERT_NOW(a_emit_ready_slot, state_reg == ST_DISP_EMIT, ready_reg[cur],
        "dispatch emitting a slot that is not ready")
    `PTT_ASSERT_NEXT(a_more_words_follow, rsp_valid && rsp_ready && !rsp.last,
        state_reg == ST_DISP_SCAN || state_reg == ST_DISP_EMIT || rsp_valid,
        "non-final word with no dispatch in progress")

endmodule

`default_nettype wire

// ----- sim/tb_periodic_task_timer_table.sv -----
`timescale 1ns / 1ps

module tb_periodic_task_timer_table;
    import ptt_pkg::*;

    localparam int SLOTS       = 16;
    localparam int TICK_LEN_MS = 10;
    localparam int HOLD_CYCLES = 400;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    ptt_cmd_t cmd = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    ptt_rsp_t rsp;

    ptt_cmd_t pending_cmds[$];
    ptt_rsp_t expected_replies[$];

    logic              tbl_used   [SLOTS];
    logic [CODE_W-1:0] tbl_code   [SLOTS];
    logic [TIME_W-1:0] tbl_delay  [SLOTS];
    logic [TIME_W-1:0] tbl_period [SLOTS];
    logic              tbl_ready  [SLOTS];

    int send_idle_pct = 18;
    int recv_idle_pct = 75;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int err_count = 0;

    periodic_task_timer_table #(
        .SLOTS      (SLOTS),
        .TICK_LEN_MS(TICK_LEN_MS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic ptt_rsp_t make_reply(logic [1:0] st, int unsigned sl,
                                            logic [CODE_W-1:0] code, logic lst);
        ptt_rsp_t r;
        r.status     = st;
        r.slot       = sl[SLOT_W-1:0];
        r.fired_code = code;
        r.last       = lst;
        return r;
    endfunction

    function automatic void free_slot(int i);
        tbl_used[i]   = 1'b0;
        tbl_code[i]   = '0;
        tbl_delay[i]  = '0;
        tbl_period[i] = '0;
        tbl_ready[i]  = 1'b0;
    endfunction

    // advance the table model by one accepted word and queue its replies
    function automatic void apply_cmd(ptt_cmd_t c);
        int i;
        int n;
        int free_idx;
        n = 0;
        free_idx = -1;
        case (c.kind)
            KIND_ADD:
            begin
                for (i = SLOTS - 1; i >= 0; i--)
                    if (!tbl_used[i])
                        free_idx = i;
                if (free_idx < 0)
                    expected_replies.push_back(make_reply(STAT_FULL, 0, '0, 1'b1));
                else
                begin
                    tbl_used[free_idx]   = 1'b1;
                    tbl_code[free_idx]   = c.task_code;
                    tbl_delay[free_idx]  = TIME_W'(c.delay_ms / TICK_LEN_MS);
                    tbl_period[free_idx] = TIME_W'(c.period_ms / TICK_LEN_MS);
                    tbl_ready[free_idx]  = 1'b0;
                    expected_replies.push_back(make_reply(STAT_DONE, free_idx, '0, 1'b1));
                end
            end
            KIND_DEL:
            begin
                if (c.slot_index < SLOTS)
                    free_slot(c.slot_index);
                expected_replies.push_back(make_reply(STAT_DONE, 0, '0, 1'b1));
            end
            KIND_TICK:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (!tbl_used[i])
                        continue;
                    if (tbl_delay[i] != 0)
                        tbl_delay[i] = tbl_delay[i] - 1'b1;
                    else
                    begin
                        tbl_ready[i] = 1'b1;
                        if (tbl_period[i] != 0)
                            tbl_delay[i] = tbl_period[i];
                    end
                end
                expected_replies.push_back(make_reply(STAT_DONE, 0, '0, 1'b1));
            end
            default:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (n >= MAX_RESULTS || !tbl_ready[i])
                        continue;
                    tbl_ready[i] = 1'b0;
                    expected_replies.push_back(make_reply(STAT_DONE, i, tbl_code[i], 1'b0));
                    n++;
                    if (tbl_period[i] == 0)
                        free_slot(i);
                end
                if (n == 0)
                    expected_replies.push_back(make_reply(STAT_NONE, 0, '0, 1'b1));
                else
                    expected_replies[expected_replies.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    function automatic void push_cmd(logic [1:0] kind, logic [CODE_W-1:0] code,
                                     logic [TIME_W-1:0] dly, logic [TIME_W-1:0] per,
                                     logic [SLOT_W-1:0] idx);
        ptt_cmd_t c;
        c.kind       = kind;
        c.task_code  = code;
        c.delay_ms   = dly;
        c.period_ms  = per;
        c.slot_index = idx;
        pending_cmds.push_back(c);
    endfunction

    function automatic ptt_cmd_t random_cmd();
        ptt_cmd_t c;
        int r;
        r = $urandom_range(99);
        if (r < 35)
            c.kind = KIND_ADD;
        else if (r < 47)
            c.kind = KIND_DEL;
        else if (r < 82)
            c.kind = KIND_TICK;
        else
            c.kind = KIND_DISP;
        c.task_code = CODE_W'($urandom_range(255));
        if ($urandom_range(99) < 85)
            c.delay_ms = TIME_W'($urandom_range(80));
        else
            c.delay_ms = TIME_W'($urandom());
        r = $urandom_range(99);
        if (r < 25)
            c.period_ms = '0;
        else if (r < 35)
            c.period_ms = TIME_W'($urandom_range(9, 1));
        else if (r < 92)
            c.period_ms = TIME_W'($urandom_range(60, 10));
        else
            c.period_ms = TIME_W'($urandom());
        if ($urandom_range(99) < 80)
            c.slot_index = SLOT_W'($urandom_range(SLOTS - 1));
        else
            c.slot_index = SLOT_W'($urandom_range(63, SLOTS));
        return c;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else
        begin
            if (cmd_valid && cmd_ready)
                apply_cmd(cmd);
            if (!cmd_valid || cmd_ready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd_valid <= 1'b1;
                    cmd <= pending_cmds.pop_front();
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        ptt_rsp_t exp_w;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_replies.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected word, expected none, got %h", $time, rsp);
            end
            else
            begin
                exp_w = expected_replies.pop_front();
                check_field("status", exp_w.status, rsp.status);
                check_field("slot", exp_w.slot, rsp.slot);
                check_field("fired_code", exp_w.fired_code, rsp.fired_code);
                check_field("last", exp_w.last, rsp.last);
            end
        end
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int i;
        int phase;
        logic [TIME_W-1:0] per;
        for (i = 0; i < SLOTS; i++)
            free_slot(i);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        push_cmd(KIND_DISP, '0, '0, '0, '0);
        for (i = 0; i < SLOTS; i++)
        begin
            case (i % 4)
                0: per = '0;
                1: per = 24'd5;
                2: per = 24'd10;
                default: per = 24'hFFFFFF;
            endcase
            push_cmd(KIND_ADD, (i == 0) ? 8'h00 : (i == SLOTS - 1) ? 8'hFF : 8'(i * 16 + 1),
                     (i % 2) ? 24'd9 : 24'd0, per, '0);
        end
        push_cmd(KIND_ADD, 8'hAA, 24'hFFFFFF, 24'hFFFFFF, 6'h3F);
        push_cmd(KIND_TICK, '0, '0, '0, '0);
        push_cmd(KIND_DISP, '0, '0, '0, '0);
        push_cmd(KIND_DEL, '0, '0, '0, 6'd63);
        push_cmd(KIND_DEL, '0, '0, '0, 6'(SLOTS));
        push_cmd(KIND_DEL, '0, '0, '0, 6'd3);
        push_cmd(KIND_ADD, 8'h5A, 24'hFFFFFF, 24'hFFFFFF, '0);
        push_cmd(KIND_TICK, '0, '0, '0, '0);
        push_cmd(KIND_TICK, '0, '0, '0, '0);
        push_cmd(KIND_DISP, '0, '0, '0, '0);

        for (phase = 0; phase < 3; phase++)
        begin
            while (pending_cmds.size() != 0)
                @(posedge clk);
            if (phase == 1)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 18;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (i = 0; i < 100; i++)
                pending_cmds.push_back(random_cmd());
            if (phase == 2)
                hold_req = hold_req + 1;
        end

        while (pending_cmds.size() != 0 || cmd_valid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (err_count == 0 && expected_replies.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/ptt_pkg.sv
rtl/core/periodic_task_timer_table.sv
sim/tb_periodic_task_timer_table.sv
